// File: design/cfr_pkg.sv
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared types and constants of the command frame receiver: frame markers,
// byte offsets, command and reply codes, and the event codes it reports.
// ----------------------------------------------------------------------------
package cfr_pkg;

	localparam int unsigned POS_W  = 6;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned IDX_W  = 32;

	localparam logic [BYTE_W-1:0] START_BYTE_0 = 8'h26;
	localparam logic [BYTE_W-1:0] START_BYTE_1 = 8'h27;

	localparam logic [POS_W-1:0] POS_START_0     = 6'd0;
	localparam logic [POS_W-1:0] POS_START_1     = 6'd1;
	localparam logic [POS_W-1:0] OFS_COMMAND     = 6'd7;
	localparam logic [POS_W-1:0] OFS_INDEX_FIRST = 6'd8;
	localparam logic [POS_W-1:0] OFS_INDEX_LAST  = 6'd11;
	localparam logic [POS_W-1:0] OFS_REPLY       = 6'd15;

	localparam logic [BYTE_W-1:0] CMD_BEGIN = 8'h01;
	localparam logic [BYTE_W-1:0] CMD_SCAN  = 8'h02;
	localparam logic [BYTE_W-1:0] CMD_REPLY = 8'h03;

	localparam logic [BYTE_W-1:0] BEGIN_MARK = 8'h01;

	localparam logic [BYTE_W-1:0] REPLY_CONTINUE = 8'h01;
	localparam logic [BYTE_W-1:0] REPLY_RESEND   = 8'h02;
	localparam logic [BYTE_W-1:0] REPLY_DONE     = 8'h03;
	localparam logic [BYTE_W-1:0] REPLY_RESUME   = 8'h04;

	typedef enum logic [2:0] {
		EV_NONE     = 3'd0,
		EV_SCAN     = 3'd1,
		EV_BEGIN    = 3'd2,
		EV_CANCEL   = 3'd3,
		EV_DONE     = 3'd4,
		EV_RESEND   = 3'd5,
		EV_CONTINUE = 3'd6,
		EV_RESUME   = 3'd7
	} event_t;

endpackage

// File: design/command_frame_receiver.sv
// ----------------------------------------------------------------------------
// command_frame_receiver
// Hunts for fixed-length command frames in a stream of received serial bytes
// and reports one decoded event with the current block index per frame.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_*: one received byte per item in s_tdata[7:0].
//   Master channel m_*: one item per completed frame; m_tdata carries the
//   event code in [2:0] and the block index in [34:3].
//   Bytes before a frame start or a wrong second byte yield no item.
//   The accepted last byte of a frame reaches m_tvalid through the input
//   register, then the result register.
//   One byte per cycle while m_tready does not stall the result register;
//   the decode between the two registers is combinational.
//   Reset clears the frame position, the captured fields and the block
//   index, and empties both registers.
//   When the receiver stalls, the result register holds and the input
//   register holds its byte; s_tready drops once both are occupied.
// ----------------------------------------------------------------------------
module command_frame_receiver #(
	parameter int unsigned FRAME_BYTES = 48
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // [2:0] event_res, [34:3] block_index, [39:35] zero
);
	import cfr_pkg::*;

	localparam logic [POS_W-1:0] POS_LAST  = POS_W'(FRAME_BYTES - 1);
	localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(FRAME_BYTES);

	logic              in_valid_s1;
	logic [BYTE_W-1:0] in_byte_s1;

	logic [POS_W-1:0]  pos_q,  pos_d;
	logic [BYTE_W-1:0] cmd_q,  cmd_d;
	logic [IDX_W-1:0]  idx_q,  idx_d;
	logic [BYTE_W-1:0] rep_q,  rep_d;
	logic [IDX_W-1:0]  xfer_q, xfer_d;

	logic              emit;
	event_t            ev;

	logic              out_valid_s2;
	event_t            out_ev_s2;
	logic [IDX_W-1:0]  out_idx_s2;

	logic out_free;
	logic proc;

	assign out_free = !out_valid_s2 || m_tready;
	assign proc     = in_valid_s1 && out_free;
	assign s_tready = !in_valid_s1 || out_free;

	always_comb begin
		pos_d  = pos_q;
		cmd_d  = cmd_q;
		idx_d  = idx_q;
		rep_d  = rep_q;
		xfer_d = xfer_q;
		emit   = 1'b0;
		ev     = EV_NONE;
		if (pos_q == POS_START_0 && in_byte_s1 != START_BYTE_0) begin
			pos_d = pos_q;
		end else if (pos_q == POS_START_1 && in_byte_s1 != START_BYTE_1) begin
			pos_d = pos_q;
		end else if (pos_q >= POS_LIMIT) begin
			pos_d = '0;
		end else begin
			if (pos_q == OFS_COMMAND) begin
				cmd_d = in_byte_s1;
			end else if (pos_q >= OFS_INDEX_FIRST && pos_q <= OFS_INDEX_LAST) begin
				idx_d = {idx_q[IDX_W-BYTE_W-1:0], in_byte_s1};
			end else if (pos_q == OFS_REPLY) begin
				rep_d = in_byte_s1;
			end
			if (pos_q == POS_LAST) begin
				pos_d = '0;
				emit  = 1'b1;
				case (cmd_d)
					CMD_SCAN: ev = EV_SCAN;
					CMD_BEGIN: begin
						if (idx_d[BYTE_W-1:0] == BEGIN_MARK) begin
							xfer_d = '0;
							ev     = EV_BEGIN;
						end else begin
							ev = EV_CANCEL;
						end
					end
					CMD_REPLY: begin
						case (rep_d)
							REPLY_DONE:     ev = EV_DONE;
							REPLY_RESEND: begin
								xfer_d = idx_d;
								ev     = EV_RESEND;
							end
							REPLY_CONTINUE: ev = EV_CONTINUE;
							REPLY_RESUME:   ev = EV_RESUME;
							default:        ev = EV_NONE;
						endcase
					end
					default: ev = EV_NONE;
				endcase
			end else begin
				pos_d = pos_q + POS_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1  <= 1'b0;
			out_valid_s2 <= 1'b0;
			pos_q        <= '0;
			cmd_q        <= '0;
			idx_q        <= '0;
			rep_q        <= '0;
			xfer_q       <= '0;
		end else begin
			if (s_tready) begin
				in_valid_s1 <= s_tvalid;
			end
			if (out_free) begin
				out_valid_s2 <= proc && emit;
			end
			if (proc) begin
				pos_q  <= pos_d;
				cmd_q  <= cmd_d;
				idx_q  <= idx_d;
				rep_q  <= rep_d;
				xfer_q <= xfer_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			in_byte_s1 <= s_tdata;
		end
		if (proc && emit) begin
			out_ev_s2  <= ev;
			out_idx_s2 <= xfer_d;
		end
	end

	assign m_tvalid = out_valid_s2;
	assign m_tdata  = {5'd0, out_idx_s2, out_ev_s2};

	a_pos_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q < POS_LIMIT)
		else $error("frame position beyond frame length");

	a_last_byte_emits: assert property (@(posedge clk) disable iff (!arst_n)
		proc && pos_q == POS_LAST |=> m_tvalid && pos_q == POS_START_0)
		else $error("last byte of frame gave no result");

	a_result_from_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(proc) && $past(pos_q) == POS_LAST)
		else $error("result without a completed frame");

	a_index_only_on_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		!(proc && pos_q == POS_LAST) |=> $stable(xfer_q))
		else $error("block index changed mid-frame");

endmodule

// File: sim/frame_event_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// frame_event_scoreboard_pkg
// Tracks the frame position and captured fields that the receiver should
// hold, predicts the event and block index reported for each completed frame,
// and checks every reported item against the oldest prediction.
// ----------------------------------------------------------------------------
package frame_event_scoreboard_pkg;

	import cfr_pkg::*;

	typedef struct {
		event_t           ev;
		logic [IDX_W-1:0] index;
	} frame_outcome_t;

	class frame_event_scoreboard;
		int unsigned       frame_len;
		logic [POS_W-1:0]  position;
		logic [BYTE_W-1:0] command;
		logic [IDX_W-1:0]  index_field;
		logic [BYTE_W-1:0] reply;
		logic [IDX_W-1:0]  block_index;
		frame_outcome_t    expected_events[$];
		int unsigned       mismatches;

		function new(int unsigned frame_len_in);
			frame_len   = frame_len_in;
			position    = '0;
			command     = '0;
			index_field = '0;
			reply       = '0;
			block_index = '0;
			mismatches  = 0;
		endfunction

		function int unsigned pending();
			return expected_events.size();
		endfunction

		function void decode_byte(logic [BYTE_W-1:0] rx);
			frame_outcome_t outcome;
			int unsigned    next_pos;
			if (position == POS_START_0 && rx != START_BYTE_0)
				return;
			if (position == POS_START_1 && rx != START_BYTE_1)
				return;
			if (position >= frame_len) begin
				position = '0;
				return;
			end
			if (position == OFS_COMMAND)
				command = rx;
			else if (position >= OFS_INDEX_FIRST && position <= OFS_INDEX_LAST)
				index_field = {index_field[IDX_W-BYTE_W-1:0], rx};
			else if (position == OFS_REPLY)
				reply = rx;
			next_pos = position + 1;
			if (next_pos < frame_len) begin
				position = next_pos[POS_W-1:0];
				return;
			end
			position = '0;
			outcome.ev = EV_NONE;
			case (command)
				CMD_SCAN: outcome.ev = EV_SCAN;
				CMD_BEGIN: begin
					if (index_field[BYTE_W-1:0] == BEGIN_MARK) begin
						block_index = '0;
						outcome.ev  = EV_BEGIN;
					end else begin
						outcome.ev = EV_CANCEL;
					end
				end
				CMD_REPLY: begin
					case (reply)
						REPLY_DONE: outcome.ev = EV_DONE;
						REPLY_RESEND: begin
							block_index = index_field;
							outcome.ev  = EV_RESEND;
						end
						REPLY_CONTINUE: outcome.ev = EV_CONTINUE;
						REPLY_RESUME: outcome.ev = EV_RESUME;
						default: outcome.ev = EV_NONE;
					endcase
				end
				default: outcome.ev = EV_NONE;
			endcase
			outcome.index = block_index;
			expected_events.push_back(outcome);
		endfunction

		function void check_result(logic [39:0] data);
			frame_outcome_t want;
			if (expected_events.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected item: event %0d index %h", data[2:0], data[34:3]);
				return;
			end
			want = expected_events.pop_front();
			if (data[2:0] !== want.ev || data[34:3] !== want.index || data[39:35] !== '0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected event %0d index %h, got event %0d index %h pad %b",
						want.ev, want.index, data[2:0], data[34:3], data[39:35]);
			end
		endfunction
	endclass

endpackage

// File: sim/command_frame_receiver_tb.sv
// ----------------------------------------------------------------------------
// command_frame_receiver_tb
// Feeds directed and random byte streams - noise, wrong second bytes, frames
// of every command and reply - into the receiver under random stalls on both
// channels and checks each reported event and block index.
// ----------------------------------------------------------------------------
module command_frame_receiver_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import cfr_pkg::*;
	import frame_event_scoreboard_pkg::*;

	localparam int unsigned FRAME_LEN = 48;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;

	frame_event_scoreboard sb;
	bit                    calm;
	int unsigned           bytes_sent;
	int unsigned           random_frames;

	command_frame_receiver #(
		.FRAME_BYTES(FRAME_LEN)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= calm || ($urandom_range(0, 99) >= 34);
	end

	task automatic send_byte(input logic [7:0] rx);
		while (!calm && $urandom_range(0, 99) < 34) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= rx;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.decode_byte(rx);
		bytes_sent++;
	endtask

	task automatic send_frame(input logic [7:0] command, input logic [31:0] index,
			input logic [7:0] reply, input logic [7:0] junk [$]);
		logic [7:0] frame_bytes [FRAME_LEN];
		for (int i = 0; i < FRAME_LEN; i++)
			frame_bytes[i] = 8'($urandom_range(0, 255));
		frame_bytes[POS_START_0] = START_BYTE_0;
		frame_bytes[POS_START_1] = START_BYTE_1;
		frame_bytes[OFS_COMMAND] = command;
		frame_bytes[OFS_INDEX_FIRST]     = index[31:24];
		frame_bytes[OFS_INDEX_FIRST + 1] = index[23:16];
		frame_bytes[OFS_INDEX_FIRST + 2] = index[15:8];
		frame_bytes[OFS_INDEX_LAST]      = index[7:0];
		frame_bytes[OFS_REPLY] = reply;
		send_byte(frame_bytes[0]);
		foreach (junk[j])
			send_byte(junk[j]);
		for (int i = 1; i < FRAME_LEN; i++)
			send_byte(frame_bytes[i]);
	endtask

	initial begin
		#2ms;
		$display("tb: failure");
		$finish;
	end

	initial begin
		logic [7:0]  none [$];
		logic [7:0]  junk [$];
		logic [7:0]  command;
		logic [7:0]  reply;
		logic [31:0] index;
		logic [7:0]  wrong;
		int unsigned roll;
		sb            = new(FRAME_LEN);
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		calm          = 1'b0;
		bytes_sent    = 0;
		random_frames = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(START_BYTE_1);
		send_frame(CMD_SCAN, 32'h0000_0000, 8'h00, none);
		send_frame(CMD_REPLY, 32'hFFFF_FFFF, REPLY_RESEND, none);
		send_frame(CMD_BEGIN, 32'hFFFF_FF00, 8'hFF, none);
		send_frame(CMD_BEGIN, 32'h0000_0001, 8'h00, none);
		junk.delete();
		junk.push_back(START_BYTE_0);
		junk.push_back(8'h00);
		junk.push_back(8'hFF);
		send_frame(CMD_REPLY, 32'h1234_5678, REPLY_RESEND, junk);
		send_frame(CMD_REPLY, 32'h0000_0000, REPLY_DONE, none);
		send_frame(CMD_REPLY, 32'h8000_0000, REPLY_CONTINUE, none);
		send_frame(CMD_REPLY, 32'h0000_0001, REPLY_RESUME, none);
		send_frame(CMD_REPLY, 32'h0000_0001, 8'h00, none);
		send_frame(CMD_REPLY, 32'h0000_0001, 8'hFF, none);
		send_frame(8'h00, 32'h0000_0001, REPLY_RESEND, none);
		send_frame(8'hFF, 32'h0000_0001, REPLY_RESEND, none);
		send_frame(CMD_REPLY, 32'h0000_0000, REPLY_RESEND, none);

		while (bytes_sent < 1450) begin
			calm = (random_frames >= 4 && random_frames < 10);
			roll = $urandom_range(0, 99);
			if (roll < 8) begin
				repeat ($urandom_range(1, 4))
					send_byte(8'($urandom_range(0, 255)));
			end else if (roll < 12) begin
				send_byte(START_BYTE_0);
				send_byte(START_BYTE_1);
				repeat ($urandom_range(1, 20))
					send_byte(8'($urandom_range(0, 255)));
			end else begin
				command = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(1, 3))
					: 8'($urandom_range(0, 255));
				reply   = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(1, 4))
					: 8'($urandom_range(0, 255));
				index   = $urandom();
				if (command == CMD_BEGIN && $urandom_range(0, 1))
					index[7:0] = BEGIN_MARK;
				junk.delete();
				if ($urandom_range(0, 99) < 15) begin
					repeat ($urandom_range(1, 3)) begin
						wrong = 8'($urandom_range(0, 255));
						if (wrong == START_BYTE_1)
							wrong = START_BYTE_0;
						junk.push_back(wrong);
					end
				end
				send_frame(command, index, reply, junk);
				random_frames++;
			end
		end
		calm = 1'b0;
		s_tvalid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
